/* sv/qrm_pkg.sv */
// shared types and constants for the quaternion to rotation matrix core
package qrm_pkg;

  localparam int COMP_W  = 16;
  localparam int FRAC_B  = 14;
  localparam int N_W     = 2 * COMP_W;           // norm width, fits below 2^32
  localparam int V_W     = N_W + 1;              // partial remainder width
  localparam int Q_W     = FRAC_B + 2;           // integer bit, fraction bits, round bit
  localparam int N_STEP  = Q_W;                  // one divider stage per quotient bit
  localparam int N_ENTRY = 9;
  localparam logic signed [COMP_W-1:0] ONE = COMP_W'(1) << FRAC_B;

  // lane order matches row-major matrix order
  localparam int E00 = 0;
  localparam int E01 = 1;
  localparam int E02 = 2;
  localparam int E10 = 3;
  localparam int E11 = 4;
  localparam int E12 = 5;
  localparam int E20 = 6;
  localparam int E21 = 7;
  localparam int E22 = 8;

  typedef struct packed {
    logic signed [COMP_W-1:0] quat_x;
    logic signed [COMP_W-1:0] quat_y;
    logic signed [COMP_W-1:0] quat_z;
    logic signed [COMP_W-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] row0_col0;
    logic signed [COMP_W-1:0] row0_col1;
    logic signed [COMP_W-1:0] row0_col2;
    logic signed [COMP_W-1:0] row1_col0;
    logic signed [COMP_W-1:0] row1_col1;
    logic signed [COMP_W-1:0] row1_col2;
    logic signed [COMP_W-1:0] row2_col0;
    logic signed [COMP_W-1:0] row2_col1;
    logic signed [COMP_W-1:0] row2_col2;
    logic                     zero_norm;
  } matrix_t;

  typedef struct packed {
    logic        [N_W-1:0] xx;
    logic        [N_W-1:0] yy;
    logic        [N_W-1:0] zz;
    logic        [N_W-1:0] ww;
    logic signed [N_W-1:0] xy;
    logic signed [N_W-1:0] wz;
    logic signed [N_W-1:0] xz;
    logic signed [N_W-1:0] wy;
    logic signed [N_W-1:0] yz;
    logic signed [N_W-1:0] wx;
  } prod_t;

  typedef struct packed {
    logic [V_W-1:0] v;
    logic           neg;
    logic [Q_W-1:0] q;
  } lane_t;

  typedef struct packed {
    logic [N_W-1:0]              n;
    logic                        zero;
    lane_t [N_ENTRY-1:0]         lane;
  } word_t;

endpackage

/* sv/quaternion_to_rotation_matrix_core.sv */
// top level: quaternion to 3x3 rotation matrix, pipelined fixed-point core
//
//  channel  | ports          | handshake
//  ---------+----------------+----------------------------------------
//  item in  | quat           | taken when start is high and busy is low
//  item out | matrix         | shown for one cycle while done is high
//
//  one item per cycle; registers in order: products, numerators, 16 divider
//  stages (integer bit, fraction bits, round bit) and the output register
//  the nine-lane restoring divider sets the depth, one quotient bit per stage
//  busy is always low; nothing waits, so no item is held or dropped
//  rst is synchronous and clears only the valid bits along the pipeline
module quaternion_to_rotation_matrix_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  qrm_pkg::quat_t   quat,
  output logic             done,
  output qrm_pkg::matrix_t matrix
);
  import qrm_pkg::*;

  // stage valids and payloads
  logic  prod_valid;
  prod_t prod;
  logic  pv [0:N_STEP];
  word_t pw [0:N_STEP];

  logic signed [COMP_W-1:0] ent [N_ENTRY];
  matrix_t                  matrix_next;
  logic [COMP_W-1:0]        mag;

  // the pipeline never stalls, so an item is always welcome
  assign busy = 1'b0;

  qrm_products u_products (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .quat      (quat),
    .out_valid (prod_valid),
    .prod      (prod)
  );

  qrm_numer u_numer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .prod      (prod),
    .out_valid (pv[0]),
    .word      (pw[0])
  );

  // divider chain: first stage gives the integer bit, last the round bit
  for (genvar s = 0; s < N_STEP; s++) begin : g_div
    qrm_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (pv[s]),
      .din       (pw[s]),
      .out_valid (pv[s+1]),
      .dout      (pw[s+1])
    );
  end

  // round half away from zero on the magnitude, then apply the sign
  always_comb begin
    mag = '0;
    for (int i = 0; i < N_ENTRY; i++) begin
      mag = COMP_W'(pw[N_STEP].lane[i].q[Q_W-1:1]) + COMP_W'(pw[N_STEP].lane[i].q[0]);
      // magnitude never exceeds one plus an lsb, so no saturation is reached
      ent[i] = pw[N_STEP].lane[i].neg ? -mag : mag;
    end
    if (pw[N_STEP].zero) begin
      // zero norm gives the identity
      for (int i = 0; i < N_ENTRY; i++) begin
        ent[i] = '0;
      end
      ent[E00] = ONE;
      ent[E11] = ONE;
      ent[E22] = ONE;
    end
    matrix_next.row0_col0 = ent[E00];
    matrix_next.row0_col1 = ent[E01];
    matrix_next.row0_col2 = ent[E02];
    matrix_next.row1_col0 = ent[E10];
    matrix_next.row1_col1 = ent[E11];
    matrix_next.row1_col2 = ent[E12];
    matrix_next.row2_col0 = ent[E20];
    matrix_next.row2_col1 = ent[E21];
    matrix_next.row2_col2 = ent[E22];
    matrix_next.zero_norm = pw[N_STEP].zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pv[N_STEP];
    end
  end

  always_ff @(posedge clk) begin
    matrix <= matrix_next;
  end

  // zero norm result is exactly the identity
  a_zero_identity: assert property (@(posedge clk) disable iff (rst)
    done && matrix.zero_norm |->
      matrix.row0_col0 == ONE && matrix.row1_col1 == ONE && matrix.row2_col2 == ONE &&
      matrix.row0_col1 == '0 && matrix.row1_col2 == '0 && matrix.row2_col0 == '0)
    else $error("zero norm item did not give the identity");

  // a rotation entry never leaves the range minus one to one
  a_diag_range: assert property (@(posedge clk) disable iff (rst)
    done |-> matrix.row0_col0 <= ONE && matrix.row0_col0 >= -ONE &&
             matrix.row1_col1 <= ONE && matrix.row1_col1 >= -ONE &&
             matrix.row2_col2 <= ONE && matrix.row2_col2 >= -ONE)
    else $error("diagonal entry out of range");

  // quotient of a bounded numerator: integer bit set means the whole fraction is zero
  a_int_bit: assert property (@(posedge clk) disable iff (rst)
    pv[N_STEP] && !pw[N_STEP].zero && pw[N_STEP].lane[E00].q[Q_W-1] |->
      pw[N_STEP].lane[E00].q[Q_W-2:0] == '0)
    else $error("divider quotient exceeds one");

  // the core takes every item offered
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

endmodule

/* sv/qrm_products.sv */
// stage one: component products and squares
module qrm_products (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  qrm_pkg::quat_t quat,
  output logic          out_valid,
  output qrm_pkg::prod_t prod
);
  import qrm_pkg::*;

  localparam logic signed [COMP_W-1:0] MOST_NEG = {1'b1, {(COMP_W-1){1'b0}}};

  logic signed [COMP_W-1:0] x, y, z, w;
  logic                     all_neg;
  prod_t                    prod_next;

  always_comb begin
    all_neg = (quat.quat_x == MOST_NEG) && (quat.quat_y == MOST_NEG) &&
              (quat.quat_z == MOST_NEG) && (quat.quat_w == MOST_NEG);
    // same rotation, keeps the norm in range
    x = all_neg ? -COMP_W'(1) : quat.quat_x;
    y = all_neg ? -COMP_W'(1) : quat.quat_y;
    z = all_neg ? -COMP_W'(1) : quat.quat_z;
    w = all_neg ? -COMP_W'(1) : quat.quat_w;
    prod_next.xx = N_W'(x) * N_W'(x);
    prod_next.yy = N_W'(y) * N_W'(y);
    prod_next.zz = N_W'(z) * N_W'(z);
    prod_next.ww = N_W'(w) * N_W'(w);
    prod_next.xy = N_W'(x) * N_W'(y);
    prod_next.wz = N_W'(w) * N_W'(z);
    prod_next.xz = N_W'(x) * N_W'(z);
    prod_next.wy = N_W'(w) * N_W'(y);
    prod_next.yz = N_W'(y) * N_W'(z);
    prod_next.wx = N_W'(w) * N_W'(x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

endmodule

/* sv/qrm_numer.sv */
// stage two: norm and signed numerators of the nine entries
module qrm_numer (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  qrm_pkg::prod_t prod,
  output logic           out_valid,
  output qrm_pkg::word_t word
);
  import qrm_pkg::*;

  word_t word_next;

  function automatic lane_t diag_lane(input logic [N_W-1:0] a0, input logic [N_W-1:0] a1,
                                      input logic [N_W-1:0] b0, input logic [N_W-1:0] b1);
    logic [V_W-1:0] a;
    logic [V_W-1:0] b;
    lane_t          l;
    a = V_W'(a0) + V_W'(a1);
    b = V_W'(b0) + V_W'(b1);
    l.q = '0;
    if (a >= b) begin
      l.neg = 1'b0;
      l.v   = a - b;
    end else begin
      l.neg = 1'b1;
      l.v   = b - a;
    end
    return l;
  endfunction

  function automatic lane_t off_lane(input logic signed [N_W-1:0] p1,
                                     input logic signed [N_W-1:0] p2, input logic sub);
    logic signed [V_W-1:0] s;
    logic        [V_W-1:0] mag;
    lane_t                 l;
    s     = sub ? (V_W'(p1) - V_W'(p2)) : (V_W'(p1) + V_W'(p2));
    l.neg = s[V_W-1];
    mag   = l.neg ? V_W'(-s) : V_W'(s);
    l.v   = {mag[N_W-1:0], 1'b0};
    l.q   = '0;
    return l;
  endfunction

  always_comb begin
    word_next.n    = N_W'((V_W+1)'(prod.xx) + (V_W+1)'(prod.yy) +
                          (V_W+1)'(prod.zz) + (V_W+1)'(prod.ww));
    word_next.zero = (word_next.n == '0);
    word_next.lane[E00] = diag_lane(prod.ww, prod.xx, prod.yy, prod.zz);
    word_next.lane[E11] = diag_lane(prod.ww, prod.yy, prod.xx, prod.zz);
    word_next.lane[E22] = diag_lane(prod.ww, prod.zz, prod.xx, prod.yy);
    word_next.lane[E01] = off_lane(prod.xy, prod.wz, 1'b1);
    word_next.lane[E10] = off_lane(prod.xy, prod.wz, 1'b0);
    word_next.lane[E02] = off_lane(prod.xz, prod.wy, 1'b0);
    word_next.lane[E20] = off_lane(prod.xz, prod.wy, 1'b1);
    word_next.lane[E12] = off_lane(prod.yz, prod.wx, 1'b1);
    word_next.lane[E21] = off_lane(prod.yz, prod.wx, 1'b0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

/* sv/qrm_div_step.sv */
// one restoring division stage, one quotient bit for all nine lanes
module qrm_div_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  qrm_pkg::word_t din,
  output logic           out_valid,
  output qrm_pkg::word_t dout
);
  import qrm_pkg::*;

  word_t          nxt;
  logic [V_W-1:0] rem;
  logic           bit_q;

  always_comb begin
    nxt   = din;
    rem   = '0;
    bit_q = 1'b0;
    for (int i = 0; i < N_ENTRY; i++) begin
      bit_q = (din.lane[i].v >= V_W'(din.n));
      rem   = bit_q ? (din.lane[i].v - V_W'(din.n)) : din.lane[i].v;
      // remainder stays below n, so doubling fits
      nxt.lane[i].v = {rem[N_W-1:0], 1'b0};
      nxt.lane[i].q = {din.lane[i].q[Q_W-2:0], bit_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule

/* bench/tb_quaternion_to_rotation_matrix_core.sv */
// testbench for the quaternion to rotation matrix core: directed table, then random quaternions
module tb_quaternion_to_rotation_matrix_core;
  timeunit 1ns;
  timeprecision 1ps;
  import qrm_pkg::*;

  localparam int LATENCY     = 19;
  localparam int N_RANDOM    = 1800;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic signed [COMP_W-1:0] MAX_C = 16'sh7fff;
  localparam logic signed [COMP_W-1:0] MIN_C = 16'sh8000;

  // one directed row: stimulus, and a typed-in answer where it is obvious
  typedef struct {
    quat_t   q;
    bit      known;
    matrix_t m;
  } dir_row_t;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  quat_t   quat;
  logic    done;
  matrix_t matrix;

  matrix_t pending_matrices[$];
  int      fail_count;
  int      cycle_count;

  quaternion_to_rotation_matrix_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .quat   (quat),
    .done   (done),
    .matrix (matrix)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // value * 2^FRAC_B / n, rounded half away from zero, then saturated
  function automatic logic signed [COMP_W-1:0] scaled_ratio(
    input logic [63:0] mag, input bit neg, input logic [63:0] n);
    logic [63:0] q;
    logic [63:0] r;
    longint      v;
    q = 0;
    r = mag;
    if (r >= n) begin
      q = 1;
      r = r - n;
    end
    for (int i = 0; i < FRAC_B; i++) begin
      q = q << 1;
      if (r >= n - r) begin
        q = q | 1;
        r = r - (n - r);
      end else begin
        r = r + r;
      end
    end
    if (r >= n - r) q = q + 1;
    v = neg ? -longint'(q) : longint'(q);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[COMP_W-1:0];
  endfunction

  // 2*(p1 +/- p2)/n for the off-diagonal entries
  function automatic logic signed [COMP_W-1:0] cross_entry(
    input longint p1, input longint p2, input bit sub, input logic [63:0] n);
    logic [63:0] u;
    logic [63:0] mag;
    u   = sub ? p1 - p2 : p1 + p2;
    mag = u[63] ? -u : u;
    return scaled_ratio(mag + mag, u[63], n);
  endfunction

  // (a - b)/n for the diagonal entries
  function automatic logic signed [COMP_W-1:0] diag_entry(
    input logic [63:0] a, input logic [63:0] b, input logic [63:0] n);
    if (a >= b) return scaled_ratio(a - b, 1'b0, n);
    return scaled_ratio(b - a, 1'b1, n);
  endfunction

  function automatic matrix_t rotation_of(input quat_t q);
    matrix_t     m;
    longint      x, y, z, w;
    logic [63:0] xx, yy, zz, ww, n;
    x = q.quat_x;
    y = q.quat_y;
    z = q.quat_z;
    w = q.quat_w;
    // all four most negative: same rotation as all minus one, keeps n in range
    if (x == -32768 && y == -32768 && z == -32768 && w == -32768) begin
      x = -1; y = -1; z = -1; w = -1;
    end
    xx = x * x;
    yy = y * y;
    zz = z * z;
    ww = w * w;
    n  = xx + yy + zz + ww;
    m  = '0;
    if (n == 0) begin
      m.row0_col0 = ONE;
      m.row1_col1 = ONE;
      m.row2_col2 = ONE;
      m.zero_norm = 1'b1;
      return m;
    end
    m.row0_col0 = diag_entry(ww + xx, yy + zz, n);
    m.row0_col1 = cross_entry(x * y, w * z, 1'b1, n);
    m.row0_col2 = cross_entry(x * z, w * y, 1'b0, n);
    m.row1_col0 = cross_entry(x * y, w * z, 1'b0, n);
    m.row1_col1 = diag_entry(ww + yy, xx + zz, n);
    m.row1_col2 = cross_entry(y * z, w * x, 1'b1, n);
    m.row2_col0 = cross_entry(x * z, w * y, 1'b1, n);
    m.row2_col1 = cross_entry(y * z, w * x, 1'b0, n);
    m.row2_col2 = diag_entry(ww + zz, xx + yy, n);
    return m;
  endfunction

  function automatic matrix_t identity_matrix(input bit zero);
    matrix_t m;
    m = '0;
    m.row0_col0 = ONE;
    m.row1_col1 = ONE;
    m.row2_col2 = ONE;
    m.zero_norm = zero;
    return m;
  endfunction

  // half scaled-down quaternions, a tenth tiny, a tenth with one dominant component, the rest raw noise
  function automatic quat_t random_quat();
    quat_t q;
    int    kind;
    kind = $urandom_range(0, 9);
    q.quat_x = COMP_W'($urandom);
    q.quat_y = COMP_W'($urandom);
    q.quat_z = COMP_W'($urandom);
    q.quat_w = COMP_W'($urandom);
    if (kind < 5) begin
      q.quat_x = $signed(q.quat_x) >>> 2;
      q.quat_y = $signed(q.quat_y) >>> 2;
      q.quat_z = $signed(q.quat_z) >>> 2;
      q.quat_w = $signed(q.quat_w) >>> 2;
    end else if (kind == 5) begin
      // tiny norms stress the divider rounding
      q.quat_x = $signed(q.quat_x) >>> 13;
      q.quat_y = $signed(q.quat_y) >>> 13;
      q.quat_z = $signed(q.quat_z) >>> 13;
      q.quat_w = $signed(q.quat_w) >>> 13;
    end else if (kind == 6) begin
      // one dominant component drives entries to their extremes
      q.quat_y = $signed(q.quat_y) >>> 8;
      q.quat_z = $signed(q.quat_z) >>> 8;
      q.quat_w = $signed(q.quat_w) >>> 8;
    end
    return q;
  endfunction

  function automatic quat_t mk(input logic signed [COMP_W-1:0] x, y, z, w);
    quat_t q;
    q.quat_x = x;
    q.quat_y = y;
    q.quat_z = z;
    q.quat_w = w;
    return q;
  endfunction

  // hand one item over, waiting out busy; predicted result queued at acceptance
  task automatic send_quat(input quat_t q, input bit known, input matrix_t m);
    start <= 1'b1;
    quat  <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_matrices.push_back(known ? m : rotation_of(q));
  endtask

  task automatic idle_burst(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // result checker: done is a strobe, every cycle counts
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_matrices.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, matrix);
        fail_count++;
      end else begin
        matrix_t e;
        e = pending_matrices.pop_front();
        if (e.row0_col0 !== matrix.row0_col0)
          $display("%0t: row0_col0 expected %0d actual %0d", $time, e.row0_col0, matrix.row0_col0);
        if (e.row0_col1 !== matrix.row0_col1)
          $display("%0t: row0_col1 expected %0d actual %0d", $time, e.row0_col1, matrix.row0_col1);
        if (e.row0_col2 !== matrix.row0_col2)
          $display("%0t: row0_col2 expected %0d actual %0d", $time, e.row0_col2, matrix.row0_col2);
        if (e.row1_col0 !== matrix.row1_col0)
          $display("%0t: row1_col0 expected %0d actual %0d", $time, e.row1_col0, matrix.row1_col0);
        if (e.row1_col1 !== matrix.row1_col1)
          $display("%0t: row1_col1 expected %0d actual %0d", $time, e.row1_col1, matrix.row1_col1);
        if (e.row1_col2 !== matrix.row1_col2)
          $display("%0t: row1_col2 expected %0d actual %0d", $time, e.row1_col2, matrix.row1_col2);
        if (e.row2_col0 !== matrix.row2_col0)
          $display("%0t: row2_col0 expected %0d actual %0d", $time, e.row2_col0, matrix.row2_col0);
        if (e.row2_col1 !== matrix.row2_col1)
          $display("%0t: row2_col1 expected %0d actual %0d", $time, e.row2_col1, matrix.row2_col1);
        if (e.row2_col2 !== matrix.row2_col2)
          $display("%0t: row2_col2 expected %0d actual %0d", $time, e.row2_col2, matrix.row2_col2);
        if (e.zero_norm !== matrix.zero_norm)
          $display("%0t: zero_norm expected %0b actual %0b", $time, e.zero_norm, matrix.zero_norm);
        if (e !== matrix) fail_count++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    matrix_t  none;
    int       drain;
    none        = '0;
    fail_count  = 0;
    cycle_count = 0;
    rst   <= 1'b1;
    start <= 1'b0;
    quat  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero norm gives the identity with the flag
    dir_rows.push_back('{mk(0, 0, 0, 0), 1'b1, identity_matrix(1'b1)});
    // unit w: identity, no flag
    dir_rows.push_back('{mk(0, 0, 0, ONE), 1'b1, identity_matrix(1'b0)});
    dir_rows.push_back('{mk(0, 0, 0, MAX_C), 1'b1, identity_matrix(1'b0)});
    dir_rows.push_back('{mk(0, 0, 0, MIN_C), 1'b1, identity_matrix(1'b0)});
    // all components most negative is replaced by all minus one
    dir_rows.push_back('{mk(MIN_C, MIN_C, MIN_C, MIN_C), 1'b0, none});
    dir_rows.push_back('{mk(-1, -1, -1, -1), 1'b0, none});
    dir_rows.push_back('{mk(MAX_C, MAX_C, MAX_C, MAX_C), 1'b0, none});
    dir_rows.push_back('{mk(MIN_C, MAX_C, MIN_C, MAX_C), 1'b0, none});
    dir_rows.push_back('{mk(MIN_C, MIN_C, MIN_C, MAX_C), 1'b0, none});
    dir_rows.push_back('{mk(ONE, 0, 0, 0), 1'b0, none});
    dir_rows.push_back('{mk(0, ONE, 0, 0), 1'b0, none});
    dir_rows.push_back('{mk(0, 0, ONE, 0), 1'b0, none});
    dir_rows.push_back('{mk(MIN_C, 0, 0, 0), 1'b0, none});
    dir_rows.push_back('{mk(0, MIN_C, 0, 0), 1'b0, none});
    dir_rows.push_back('{mk(0, 0, MAX_C, 0), 1'b0, none});
    dir_rows.push_back('{mk(1, 0, 0, 0), 1'b0, none});
    dir_rows.push_back('{mk(1, 1, 0, 0), 1'b0, none});
    dir_rows.push_back('{mk(1, -1, 1, -1), 1'b0, none});
    dir_rows.push_back('{mk(11585, 0, 0, 11585), 1'b0, none});
    dir_rows.push_back('{mk(0, 11585, 0, -11585), 1'b0, none});
    dir_rows.push_back('{mk(8192, 8192, 8192, 8192), 1'b0, none});
    dir_rows.push_back('{mk(3, 5, 7, 11), 1'b0, none});
    dir_rows.push_back('{mk(-32767, 1, -1, 2), 1'b0, none});

    foreach (dir_rows[i]) send_quat(dir_rows[i].q, dir_rows[i].known, dir_rows[i].m);

    // sender holds off until the pipe has emptied
    start <= 1'b0;
    while (pending_matrices.size() != 0) @(posedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      // random idle bursts, none in the last stretch
      if (i < N_RANDOM - 300 && $urandom_range(0, 5) == 0)
        idle_burst($urandom_range(1, 8));
      send_quat(random_quat(), 1'b0, none);
    end
    start <= 1'b0;

    while (pending_matrices.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < LATENCY + 5) begin
      @(posedge clk);
      drain++;
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
